// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL; clk and rst_n must be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SED_ASSERT_NEVER(label, expr, msg) \
  `SED_ASSERT(label, !(expr), msg)

`endif

// ----- rtl/sed_pkg.sv -----
`default_nettype none

package sed_pkg;

  // Error codes of a result word
  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_UNKNOWN      = 2'd1,
    ERR_NO_DIGITS    = 2'd2,
    ERR_TRAIL_BSLASH = 2'd3
  } err_t;

  // Decoder mode, one-hot
  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_HEX    = 3'b100
  } mode_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_U_LO   = 8'h75;
  localparam logic [7:0] CH_U_UP   = 8'h55;

  localparam logic [3:0] LIM_X  = 4'd2;
  localparam logic [3:0] LIM_U  = 4'd4;
  localparam logic [3:0] LIM_UU = 4'd8;

  typedef struct packed {
    logic [31:0] value;
    logic        is_cp;
    err_t        err;
    logic        last_of_run;
    logic        eos;
  } res_t;

  // One queue entry: the results caused by one input byte
  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } rec_t;

  function automatic res_t sed_mk_res(input logic [31:0] value, input logic is_cp,
                                      input err_t err);
    res_t r;
    r.value       = value;
    r.is_cp       = is_cp;
    r.err         = err;
    r.last_of_run = 1'b0;
    r.eos         = 1'b0;
    return r;
  endfunction

  // {hit, code} for the single-letter escapes
  function automatic logic [8:0] sed_simple_esc(input logic [7:0] b);
    logic [8:0] r;
    unique case (b)
      8'h30:   r = {1'b1, 8'd0};   // 0
      8'h61:   r = {1'b1, 8'd7};   // a
      8'h62:   r = {1'b1, 8'd8};   // b
      8'h5C:   r = {1'b1, 8'd92};  // backslash
      8'h74:   r = {1'b1, 8'd9};   // t
      8'h6E:   r = {1'b1, 8'd10};  // n
      8'h66:   r = {1'b1, 8'd12};  // f
      8'h72:   r = {1'b1, 8'd13};  // r
      8'h76:   r = {1'b1, 8'd11};  // v
      8'h27:   r = {1'b1, 8'd39};  // single quote
      8'h22:   r = {1'b1, 8'd34};  // double quote
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // {hit, digit} for a hex digit of either case
  function automatic logic [4:0] sed_hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sed_in_if.sv -----
`default_nettype none

interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/sed_out_if.sv -----
`default_nettype none

interface sed_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_value;
  logic        is_code_point;
  logic [1:0]  error_code;
  logic        last_of_run;
  logic        end_of_string;

  modport source (output valid, output out_value, output is_code_point,
                  output error_code, output last_of_run, output end_of_string,
                  input ready);
  modport sink   (input valid, input out_value, input is_code_point,
                  input error_code, input last_of_run, input end_of_string,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/sed_front.sv -----
`default_nettype none
`include "assert_macros.svh"

module sed_front import sed_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  sed_in_if.sink    in_ch,
  input  wire logic q_full,
  output logic      push,
  output rec_t      push_rec
);

  typedef struct packed {
    logic emit;
    logic to_esc;
    res_t res;
  } norm_t;

  mode_t       mode_r, mode_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [3:0]  lim_r, lim_nxt;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic [8:0]  simple;
  logic [4:0]  hexv;
  logic        r0_v, r1_v;
  res_t        r0, r1;
  norm_t       norm;

  // Plain byte outside an escape
  function automatic norm_t normal_byte(input logic [7:0] c, input logic lst);
    norm_t n;
    n.emit   = 1'b1;
    n.to_esc = 1'b0;
    n.res    = sed_mk_res({24'd0, c}, 1'b0, ERR_NONE);
    if (c == CH_BSLASH) begin
      if (lst) begin
        n.res = sed_mk_res(32'd0, 1'b1, ERR_TRAIL_BSLASH);
      end else begin
        n.emit   = 1'b0;
        n.to_esc = 1'b1;
      end
    end
    return n;
  endfunction

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;
  assign b           = in_ch.text_byte;
  assign last        = in_ch.last_byte;
  assign simple      = sed_simple_esc(b);
  assign hexv        = sed_hex_val(b);
  assign norm        = normal_byte(b, last);

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    lim_nxt  = lim_r;
    r0_v     = 1'b0;
    r1_v     = 1'b0;
    r0       = sed_mk_res(32'd0, 1'b0, ERR_NONE);
    r1       = sed_mk_res(32'd0, 1'b0, ERR_NONE);
    unique case (mode_r)
      MODE_NORMAL: begin
        r0_v     = norm.emit;
        r0       = norm.res;
        mode_nxt = norm.to_esc ? MODE_ESCAPE : MODE_NORMAL;
      end
      MODE_ESCAPE: begin
        mode_nxt = MODE_NORMAL;
        if (simple[8]) begin
          r0_v = 1'b1;
          r0   = sed_mk_res({24'd0, simple[7:0]}, 1'b1, ERR_NONE);
        end else if (b == CH_X || b == CH_U_LO || b == CH_U_UP) begin
          lim_nxt = (b == CH_X) ? LIM_X : ((b == CH_U_LO) ? LIM_U : LIM_UU);
          cnt_nxt = 4'd0;
          acc_nxt = 32'd0;
          if (last) begin
            r0_v = 1'b1;
            r0   = sed_mk_res(32'd0, 1'b1, ERR_NO_DIGITS);
          end else begin
            mode_nxt = MODE_HEX;
          end
        end else begin
          r0_v = 1'b1;
          r0   = sed_mk_res({24'd0, b}, 1'b1, ERR_UNKNOWN);
        end
      end
      MODE_HEX: begin
        if (hexv[4]) begin
          acc_nxt = {acc_r[27:0], hexv[3:0]};
          cnt_nxt = cnt_r + 4'd1;
          if (cnt_nxt >= lim_r || last) begin
            mode_nxt = MODE_NORMAL;
            r0_v     = 1'b1;
            r0       = sed_mk_res(acc_nxt, 1'b1, ERR_NONE);
          end
        end else begin
          r0_v = 1'b1;
          r0   = (cnt_r == 4'd0) ? sed_mk_res(32'd0, 1'b1, ERR_NO_DIGITS)
                                 : sed_mk_res(acc_r, 1'b1, ERR_NONE);
          r1_v     = norm.emit;
          r1       = norm.res;
          mode_nxt = norm.to_esc ? MODE_ESCAPE : MODE_NORMAL;
        end
      end
      default: mode_nxt = MODE_NORMAL;
    endcase
    if (r1_v) begin
      r1.last_of_run = 1'b1;
      r1.eos         = last;
    end else begin
      r0.last_of_run = 1'b1;
      r0.eos         = last;
    end
  end

  assign push         = accept && r0_v;
  assign push_rec.two = r1_v;
  assign push_rec.r0  = r0;
  assign push_rec.r1  = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= 32'd0;
      cnt_r  <= 4'd0;
      lim_r  <= 4'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      lim_r  <= lim_nxt;
    end
  end

  `SED_ASSERT(a_hex_limit,
              (mode_r == MODE_HEX) |->
                ((lim_r == LIM_X || lim_r == LIM_U || lim_r == LIM_UU) && cnt_r < lim_r),
              "hex digit count out of range")
  `SED_ASSERT(a_last_leaves_normal,
              (accept && in_ch.last_byte) |=> (mode_r == MODE_NORMAL),
              "string end left decoder inside an escape")

endmodule

`default_nettype wire

// ----- rtl/sed_queue.sv -----
`default_nettype none
`include "assert_macros.svh"

module sed_queue import sed_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  rec_t      push_rec,
  output logic      full,
  output logic      head_valid,
  output rec_t      head_rec,
  input  wire logic pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_rec   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `SED_ASSERT_NEVER(a_no_overflow, push && full, "queue written while full")
  `SED_ASSERT_NEVER(a_no_underflow, pop && !head_valid, "queue read while empty")

endmodule

`default_nettype wire

// ----- rtl/sed_back.sv -----
`default_nettype none
`include "assert_macros.svh"

module sed_back import sed_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic head_valid,
  input  rec_t      head_rec,
  output logic      pop,
  sed_out_if.source out_ch
);

  logic out_valid_r;
  res_t out_res_r;
  logic second_r;
  logic load;

  assign load = head_valid && (!out_valid_r || out_ch.ready);
  assign pop  = load && (second_r || !head_rec.two);

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= second_r ? head_rec.r1 : head_rec.r0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      second_r    <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      second_r    <= !second_r && head_rec.two;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_value     = out_res_r.value;
  assign out_ch.is_code_point = out_res_r.is_cp;
  assign out_ch.error_code    = out_res_r.err;
  assign out_ch.last_of_run   = out_res_r.last_of_run;
  assign out_ch.end_of_string = out_res_r.eos;

  `SED_ASSERT(a_second_has_head,
              second_r |-> (head_valid && head_rec.two),
              "second result pending without its entry")

endmodule

`default_nettype wire

// ----- rtl/string_escape_decoder_top.sv -----
// Channel   Direction  Word
// in_ch     in         text_byte[7:0], last_byte
// out_ch    out        out_value[31:0], is_code_point, error_code[1:0],
//                      last_of_run, end_of_string
//
// One input byte is taken per cycle while the queue has room; the decode
// state machine in the front end updates in that same cycle.
// The back end sends one result word per cycle while the receiver is ready, so
// a byte with two results sends them one after the other; the queue absorbs
// the extra word. A byte's results pass the queue, then the output register.
// Reset is synchronous and active low; it returns the decoder to normal mode
// and empties the queue. in_ch.ready drops only when the queue is full.
`default_nettype none

module string_escape_decoder_top import sed_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sed_in_if.sink    in_ch,
  sed_out_if.source out_ch
);

  logic q_full;
  logic push;
  rec_t push_rec;
  logic head_valid;
  rec_t head_rec;
  logic pop;

  // Front end: classify each byte, track escape state, form result entries
  sed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  // Queue decouples the byte stream from the result stream
  sed_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop)
  );

  // Back end: drain each entry one result word at a time into the output register
  sed_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
module testbench;
  import sed_pkg::*;

  // One byte waiting to be offered to the decoder
  typedef struct {
    logic [7:0] text;
    logic       last;
    bit         drain;   // hold this byte back until every expected word is out
  } text_item_t;

  localparam int RAND_BYTES     = 1900;
  localparam int IDLE_PCT       = 9;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int HOLDOFF_AT     = 700;   // bytes taken before the long receiver hold-off
  localparam int HOLDOFF_CYCLES = 100;
  localparam int DRAIN_AT       = 1300;  // pending index of the mid-run sender pause
  localparam int CALM_FROM      = 1000;  // cycle window with no idling on either side
  localparam int CALM_TO        = 1600;

  localparam logic [7:0] SIMPLE_LETTERS [11] = '{
    "0", "a", "b", CH_BSLASH, "t", "n", "f", "r", "v", "'", "\""
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sed_in_if  in_bus();
  sed_out_if out_bus();

  string_escape_decoder_top DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus)
  );

  always #6 clk = ~clk;

  // Decoder state as the prediction sees it; reset values
  mode_t       dec_mode = MODE_NORMAL;
  logic [31:0] hex_acc  = '0;
  logic [3:0]  hex_cnt  = '0;
  logic [3:0]  hex_lim  = '0;

  text_item_t  pending_bytes[$];
  res_t        expected_words[$];
  logic [7:0]  str_buf[$];

  int fail_count       = 0;
  int bytes_taken      = 0;
  int words_seen       = 0;
  int code_points_seen = 0;
  int errors_seen      = 0;
  int cycle_count      = 0;
  int quiet_cycles     = 0;
  int hold_left        = 0;
  bit hold_done        = 1'b0;
  bit in_fire          = 1'b0;

  // Value of a hex digit of either case; 0 when the byte is no hex digit
  function automatic bit hex_digit(input logic [7:0] b, output logic [3:0] d);
    hex_digit = 1'b1;
    d = 4'd0;
    if (b >= "0" && b <= "9") begin
      d = 4'(b - "0");
    end else if (b >= "a" && b <= "f") begin
      d = 4'(b - "a" + 8'd10);
    end else if (b >= "A" && b <= "F") begin
      d = 4'(b - "A" + 8'd10);
    end else begin
      hex_digit = 1'b0;
    end
  endfunction

  // Code of a single-letter escape; 0 when the letter is not one
  function automatic bit escape_code(input logic [7:0] b, output logic [7:0] code);
    escape_code = 1'b1;
    case (b)
      "0":       code = 8'h00;
      "a":       code = 8'h07;
      "b":       code = 8'h08;
      "t":       code = 8'h09;
      "n":       code = 8'h0A;
      "v":       code = 8'h0B;
      "f":       code = 8'h0C;
      "r":       code = 8'h0D;
      "\"":      code = 8'h22;
      "'":       code = 8'h27;
      CH_BSLASH: code = CH_BSLASH;
      default: begin
        code = 8'h00;
        escape_code = 1'b0;
      end
    endcase
  endfunction

  function automatic res_t make_word(input logic [31:0] v, input logic cp, input err_t e);
    res_t w;
    w.value       = v;
    w.is_cp       = cp;
    w.err         = e;
    w.last_of_run = 1'b0;
    w.eos         = 1'b0;
    return w;
  endfunction

  // Advance the decoder state by one accepted byte and queue the words it yields
  task automatic decode_byte(input logic [7:0] b, input logic last);
    res_t       words[2];
    int         n;
    logic [7:0] code;
    logic [3:0] d;
    bit         as_plain;
    n = 0;
    as_plain = 1'b0;
    case (dec_mode)
      MODE_ESCAPE: begin
        dec_mode = MODE_NORMAL;
        if (escape_code(b, code)) begin
          words[n++] = make_word({24'd0, code}, 1'b1, ERR_NONE);
        end else if (b == CH_X || b == CH_U_LO || b == CH_U_UP) begin
          hex_lim = (b == CH_X) ? LIM_X : ((b == CH_U_LO) ? LIM_U : LIM_UU);
          hex_cnt = '0;
          hex_acc = '0;
          if (last) begin
            words[n++] = make_word(32'd0, 1'b1, ERR_NO_DIGITS);
          end else begin
            dec_mode = MODE_HEX;
          end
        end else begin
          words[n++] = make_word({24'd0, b}, 1'b1, ERR_UNKNOWN);
        end
      end
      MODE_HEX: begin
        if (hex_digit(b, d)) begin
          hex_acc = {hex_acc[27:0], d};
          hex_cnt = hex_cnt + 4'd1;
          if (hex_cnt >= hex_lim || last) begin
            dec_mode = MODE_NORMAL;
            words[n++] = make_word(hex_acc, 1'b1, ERR_NONE);
          end
        end else begin
          // close the escape, then treat the byte as ordinary text
          if (hex_cnt == 4'd0) begin
            words[n++] = make_word(32'd0, 1'b1, ERR_NO_DIGITS);
          end else begin
            words[n++] = make_word(hex_acc, 1'b1, ERR_NONE);
          end
          dec_mode = MODE_NORMAL;
          as_plain = 1'b1;
        end
      end
      default: as_plain = 1'b1;
    endcase
    if (as_plain) begin
      if (b == CH_BSLASH) begin
        if (last) begin
          dec_mode = MODE_NORMAL;
          words[n++] = make_word(32'd0, 1'b1, ERR_TRAIL_BSLASH);
        end else begin
          dec_mode = MODE_ESCAPE;
        end
      end else begin
        dec_mode = MODE_NORMAL;
        words[n++] = make_word({24'd0, b}, 1'b0, ERR_NONE);
      end
    end
    if (n > 0) begin
      words[n-1].last_of_run = 1'b1;
      words[n-1].eos         = last;
    end
    for (int i = 0; i < n; i++) begin
      expected_words.push_back(words[i]);
    end
  endtask

  // Move str_buf into the pending queue as one string, flagging its final byte
  task automatic flush_string();
    text_item_t it;
    while (str_buf.size() > 0) begin
      it.text  = str_buf.pop_front();
      it.last  = (str_buf.size() == 0);
      it.drain = 1'b0;
      pending_bytes.push_back(it);
    end
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      str_buf.push_back(s[i]);
    end
    flush_string();
  endtask

  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  // Mostly well-formed strings of random tokens; some are plain noise
  task automatic add_random_string();
    int         tokens;
    int         pick;
    int         ndig;
    logic [7:0] b;
    logic [3:0] lim;
    if ($urandom_range(0, 99) < 10) begin
      repeat ($urandom_range(1, 8)) str_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      tokens = $urandom_range(1, 6);
      repeat (tokens) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_BSLASH) b = b ^ 8'h01;
          str_buf.push_back(b);
        end else if (pick < 55) begin
          str_buf.push_back(CH_BSLASH);
          str_buf.push_back(SIMPLE_LETTERS[$urandom_range(0, 10)]);
        end else if (pick < 85) begin
          case ($urandom_range(0, 2))
            0: begin b = CH_X;    lim = LIM_X;  end
            1: begin b = CH_U_LO; lim = LIM_U;  end
            default: begin b = CH_U_UP; lim = LIM_UU; end
          endcase
          str_buf.push_back(CH_BSLASH);
          str_buf.push_back(b);
          // favour the full digit count so the limit is hit often
          ndig = ($urandom_range(0, 1) == 0) ? int'(lim) : $urandom_range(0, int'(lim));
          repeat (ndig) str_buf.push_back(rand_hex_char());
        end else if (pick < 93) begin
          str_buf.push_back(CH_BSLASH);
          str_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
          str_buf.push_back(8'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 99) < 5) str_buf.push_back(CH_BSLASH);
    end
    flush_string();
  endtask

  function automatic bit calm_window();
    return cycle_count >= CALM_FROM && cycle_count < CALM_TO;
  endfunction

  // Input side: note each accepted byte and predict what it yields
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    in_fire = rst_n && in_bus.valid && in_bus.ready;
    if (in_fire) begin
      bytes_taken = bytes_taken + 1;
      decode_byte(in_bus.text_byte, in_bus.last_byte);
    end
  end

  // Driver: offer the next pending byte once the current one is taken
  always @(negedge clk) begin : drive_bytes
    bit         offer;
    text_item_t it;
    offer = 1'b0;
    if (rst_n && (!in_bus.valid || in_fire)) begin
      if (pending_bytes.size() > 0 &&
          !(pending_bytes[0].drain && expected_words.size() > 0) &&
          (calm_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
        it = pending_bytes.pop_front();
        in_bus.text_byte <= it.text;
        in_bus.last_byte <= it.last;
        offer = 1'b1;
      end
      in_bus.valid <= offer;
    end
  end

  // Receiver: random stalls, plus one long hold-off to fill the decoder
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_bus.ready <= 1'b0;
    end else if (!hold_done && bytes_taken >= HOLDOFF_AT) begin
      hold_done = 1'b1;
      hold_left = HOLDOFF_CYCLES - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: compare each result word with the oldest expected one
  always @(posedge clk) begin : check_words
    res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      words_seen = words_seen + 1;
      if (out_bus.is_code_point) code_points_seen = code_points_seen + 1;
      if (out_bus.error_code != ERR_NONE) errors_seen = errors_seen + 1;
      if (expected_words.size() == 0) begin
        fail_count = fail_count + 1;
        $display("%0t: unexpected word: value=%h cp=%b err=%0d lor=%b eos=%b", $time,
                 out_bus.out_value, out_bus.is_code_point, out_bus.error_code,
                 out_bus.last_of_run, out_bus.end_of_string);
      end else begin
        want = expected_words.pop_front();
        if ({want.value, want.is_cp, want.err, want.last_of_run, want.eos} !==
            {out_bus.out_value, out_bus.is_code_point, out_bus.error_code,
             out_bus.last_of_run, out_bus.end_of_string}) begin
          fail_count = fail_count + 1;
          $display("%0t: mismatch: expected value=%h cp=%b err=%0d lor=%b eos=%b", $time,
                   want.value, want.is_cp, want.err, want.last_of_run, want.eos);
          $display("%0t:           actual   value=%h cp=%b err=%0d lor=%b eos=%b", $time,
                   out_bus.out_value, out_bus.is_code_point, out_bus.error_code,
                   out_bus.last_of_run, out_bus.end_of_string);
        end
      end
    end
  end

  // Watchdog: give up when no word moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: nothing accepted for %0d cycles, %0d words still expected",
               $time, quiet_cycles, expected_words.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int         directed_n;
    text_item_t it;
    in_bus.valid     = 1'b0;
    in_bus.text_byte = 8'h00;
    in_bus.last_byte = 1'b0;
    out_bus.ready    = 1'b0;

    // Directed: byte extremes, a simple escape, hex limit, early close,
    // missing digits, unknown letter, end of string inside and after escapes
    str_buf.push_back(8'h00);
    str_buf.push_back(8'hFF);
    flush_string();
    add_text("\\\"");
    add_text("\\x41");
    add_text("\\uaFz");
    add_text("\\xg");
    add_text("\\q");
    add_text("\\U7");
    add_text("\\x");
    add_text("\\");
    add_text("\\u1\\");
    directed_n = pending_bytes.size();

    while (pending_bytes.size() < directed_n + RAND_BYTES) add_random_string();

    // Pause the sender until the decoder has drained, once after the
    // directed part and once mid-run
    it = pending_bytes[directed_n];
    it.drain = 1'b1;
    pending_bytes[directed_n] = it;
    it = pending_bytes[DRAIN_AT];
    it.drain = 1'b1;
    pending_bytes[DRAIN_AT] = it;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last byte to go in, the last word to come out, then settle
    while (pending_bytes.size() > 0 || in_bus.valid) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d input bytes and %0d result words (%0d escape results, %0d errors),",
             bytes_taken, words_seen, code_points_seen, errors_seen);
    $display("with random stalls, one long receiver hold-off and two sender drain pauses.");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
